>>> hdl/bsfr_pkg.sv
// Shared types and constants for the byte-stuffed frame receiver.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package bsfr_pkg;

	localparam int BYTE_W = 8;
	localparam int CFG_W  = 7;
	localparam int IDX_W  = 6;

	localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
	localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
	localparam logic [BYTE_W-1:0] ESC_XOR   = 8'h20;
	localparam int                MIN_FRAME = 3;

	localparam logic [CFG_W-1:0] MAX_LEN_RESET = 7'd64;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_SHORT = 1'b1;

	// Events raised by the parser for one accepted byte
	typedef struct packed {
		logic wr;          // store one body byte
		logic close;       // closing flag after a non-empty body
		logic short_frame; // closed body is under the minimum frame length
	} parse_ev_t;

endpackage

>>> hdl/bsfr_parser.sv
// Byte-level deframing: flag hunting, escape handling and body length check.
// Depends on bsfr_pkg; drives the frame store write and close events.
`timescale 1ns / 1ps

module bsfr_parser #(
	parameter int MAX_BODY_BYTES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [bsfr_pkg::BYTE_W-1:0]   rx_byte,
	input  logic [bsfr_pkg::CFG_W-1:0]    max_len,
	output bsfr_pkg::parse_ev_t           ev,
	output logic [bsfr_pkg::BYTE_W-1:0]   wr_data,
	output logic [$clog2(MAX_BODY_BYTES+1)-1:0] count
);

	localparam int CW = $clog2(MAX_BODY_BYTES + 1);
	localparam logic [bsfr_pkg::CFG_W-1:0] MAX_LIM = bsfr_pkg::CFG_W'(MAX_BODY_BYTES);

	logic          in_frame_q, in_frame_d;
	logic          esc_q, esc_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [bsfr_pkg::CFG_W-1:0] limit;

	assign limit   = (max_len > MAX_LIM) ? MAX_LIM : max_len;
	assign count   = cnt_q;
	assign wr_data = esc_q ? (rx_byte ^ bsfr_pkg::ESC_XOR) : rx_byte;

	always_comb begin
		in_frame_d     = in_frame_q;
		esc_d          = esc_q;
		cnt_d          = cnt_q;
		ev.wr          = 1'b0;
		ev.close       = 1'b0;
		ev.short_frame = 1'b0;
		if (accept) begin
			if (!in_frame_q) begin
				if (rx_byte == bsfr_pkg::FLAG_BYTE) begin
					in_frame_d = 1'b1;
					esc_d      = 1'b0;
					cnt_d      = '0;
				end
			end else if (rx_byte == bsfr_pkg::ESC_BYTE) begin
				esc_d = 1'b1;
			end else if (rx_byte == bsfr_pkg::FLAG_BYTE) begin
				esc_d = 1'b0;
				if (cnt_q != '0) begin
					ev.close       = 1'b1;
					ev.short_frame = (cnt_q < CW'(bsfr_pkg::MIN_FRAME));
					cnt_d          = '0;
				end
			end else if (bsfr_pkg::CFG_W'(cnt_q) >= limit) begin
				// drop the frame and hunt again
				in_frame_d = 1'b0;
				esc_d      = 1'b0;
				cnt_d      = '0;
			end else begin
				ev.wr = 1'b1;
				esc_d = 1'b0;
				cnt_d = CW'(cnt_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			cnt_q      <= '0;
		end else begin
			in_frame_q <= in_frame_d;
			esc_q      <= esc_d;
			cnt_q      <= cnt_d;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_BODY_BYTES))
		else $error("body count beyond store depth");

	a_wr_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		ev.wr |-> in_frame_q && (bsfr_pkg::CFG_W'(cnt_q) < limit))
		else $error("store write outside a frame or past the limit");

endmodule

>>> hdl/byte_stuffed_frame_receiver_unit.sv
// Top level of the byte-stuffed frame receiver: frame store, readout and output register.
// Depends on bsfr_pkg and bsfr_parser.
`timescale 1ns / 1ps

// Raw line bytes are taken one per cycle while no readout is running (in_stall low);
// each unescaped body byte goes into a frame store of MAX_BODY_BYTES entries with
// one write and one registered read port. A closing flag after a non-empty body
// starts the readout and the input stalls until it ends: each stored byte passes
// through ST_READ for the store's registered read and ST_LOAD to load the output
// register, which waits while the output is stalled (a short frame gives one error
// result instead). The store needs no clearing pass after reset. The length limit is
// to be written through cfg_wr_en/cfg_wr_data while idle; the block does not check it.
module byte_stuffed_frame_receiver_unit #(
	parameter int MAX_BODY_BYTES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [bsfr_pkg::CFG_W-1:0]  cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [bsfr_pkg::BYTE_W-1:0] rx_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        status,
	output logic [bsfr_pkg::BYTE_W-1:0] data_byte,
	output logic [bsfr_pkg::IDX_W-1:0]  byte_index,
	output logic                        last
);

	localparam int CW = $clog2(MAX_BODY_BYTES + 1);
	localparam int AW = $clog2(MAX_BODY_BYTES);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_LOAD = 4'b0100,
		ST_ERR  = 4'b1000
	} rd_state_t;

	rd_state_t state_q;

	logic [bsfr_pkg::CFG_W-1:0]  max_len_q;
	logic                        accept;
	bsfr_pkg::parse_ev_t         ev;
	logic [bsfr_pkg::BYTE_W-1:0] wr_data;
	logic [CW-1:0]               count;

	logic [bsfr_pkg::BYTE_W-1:0] mem [MAX_BODY_BYTES];
	logic [bsfr_pkg::BYTE_W-1:0] rd_data_s1;
	logic [AW-1:0]               rd_idx_q;
	logic [CW-1:0]               n_q;
	logic                        rd_last;
	logic                        slot_free;
	logic                        load_en;

	logic                        out_valid_q;
	logic                        status_q;
	logic [bsfr_pkg::BYTE_W-1:0] data_q;
	logic [bsfr_pkg::IDX_W-1:0]  index_q;
	logic                        last_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign load_en   = (state_q == ST_LOAD || state_q == ST_ERR) && slot_free;
	assign rd_last   = (CW'(rd_idx_q) + CW'(1)) == n_q;

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign data_byte  = data_q;
	assign byte_index = index_q;
	assign last       = last_q;

	bsfr_parser #(
		.MAX_BODY_BYTES(MAX_BODY_BYTES)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.max_len (max_len_q),
		.ev      (ev),
		.wr_data (wr_data),
		.count   (count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= bsfr_pkg::MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ev.wr) begin
			mem[count[AW-1:0]] <= wr_data;
		end
		rd_data_s1 <= mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			rd_idx_q    <= '0;
		end else begin
			if (load_en) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (ev.close) begin
						rd_idx_q <= '0;
						state_q  <= ev.short_frame ? ST_ERR : ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (slot_free) begin
						if (rd_last) begin
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= AW'(rd_idx_q + 1'b1);
							state_q  <= ST_READ;
						end
					end
				end
				ST_ERR: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && ev.close) begin
			n_q <= count;
		end
		if (state_q == ST_LOAD && slot_free) begin
			status_q <= bsfr_pkg::STATUS_OK;
			data_q   <= rd_data_s1;
			index_q  <= bsfr_pkg::IDX_W'(rd_idx_q);
			last_q   <= rd_last;
		end else if (state_q == ST_ERR && slot_free) begin
			status_q <= bsfr_pkg::STATUS_SHORT;
			data_q   <= '0;
			index_q  <= '0;
			last_q   <= 1'b1;
		end
	end

	a_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ev.wr |-> state_q == ST_IDLE)
		else $error("frame store written during readout");

	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (CW'(rd_idx_q) < n_q) && (n_q >= CW'(bsfr_pkg::MIN_FRAME)))
		else $error("readout index outside the closed frame");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_LOAD || state_q == ST_ERR) && slot_free) |=> out_valid)
		else $error("result not presented after load");

	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == bsfr_pkg::STATUS_SHORT) |-> last && data_byte == '0)
		else $error("error result without last mark or with data");

endmodule

>>> dv/byte_stuffed_frame_receiver_unit_test.sv
// Self-checking testbench for byte_stuffed_frame_receiver_unit: a directed table, then random
// frames with escapes, short, empty and oversized bodies under several length limits.
// Depends on bsfr_pkg and the RTL of the block; results are checked against an in-bench predictor.
`timescale 1ns / 1ps

module byte_stuffed_frame_receiver_unit_test;

	localparam int STORE_DEPTH    = 64;
	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASE_BYTES    = 40;
	localparam int N_PHASES       = 6;

	typedef struct packed {
		logic                        status;
		logic [bsfr_pkg::BYTE_W-1:0] data;
		logic [bsfr_pkg::IDX_W-1:0]  idx;
		logic                        last;
	} frame_res_t;

	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                   kind;
		logic [bsfr_pkg::BYTE_W-1:0] value;
		bit                          typed;    // expectation written in the row, not predicted
		bit                          want_err; // typed row expects one short-frame result
	} stim_row_t;

	localparam frame_res_t SHORT_RES =
		'{status: bsfr_pkg::STATUS_SHORT, data: '0, idx: '0, last: 1'b1};

	localparam int N_DIR = 31;
	stim_row_t dir_tbl [N_DIR] = '{
		'{ROW_BYTE, 8'h00, 1'b1, 1'b0},
		'{ROW_BYTE, 8'hFF, 1'b1, 1'b0},
		'{ROW_BYTE, 8'h7E, 1'b1, 1'b0},
		'{ROW_BYTE, 8'h7E, 1'b1, 1'b0},
		'{ROW_BYTE, 8'h41, 1'b0, 1'b0},
		'{ROW_BYTE, 8'h7E, 1'b1, 1'b1},
		'{ROW_BYTE, 8'h00, 1'b0, 1'b0},
		'{ROW_BYTE, 8'hFF, 1'b0, 1'b0},
		'{ROW_BYTE, 8'h7E, 1'b1, 1'b1},
		'{ROW_BYTE, 8'h01, 1'b0, 1'b0},
		'{ROW_BYTE, 8'h7D, 1'b0, 1'b0},
		'{ROW_BYTE, 8'h7D, 1'b0, 1'b0},
		'{ROW_BYTE, 8'h5E, 1'b0, 1'b0},
		'{ROW_BYTE, 8'h7D, 1'b0, 1'b0},
		'{ROW_BYTE, 8'h5D, 1'b0, 1'b0},
		'{ROW_BYTE, 8'h7E, 1'b0, 1'b0},
		'{ROW_BYTE, 8'h7D, 1'b0, 1'b0},
		'{ROW_BYTE, 8'h7E, 1'b1, 1'b0},
		'{ROW_BYTE, 8'h20, 1'b0, 1'b0},
		'{ROW_BYTE, 8'h7E, 1'b1, 1'b1},
		'{ROW_CFG,  8'd3,  1'b0, 1'b0},
		'{ROW_BYTE, 8'hAA, 1'b0, 1'b0},
		'{ROW_BYTE, 8'hBB, 1'b0, 1'b0},
		'{ROW_BYTE, 8'hCC, 1'b0, 1'b0},
		'{ROW_BYTE, 8'h7E, 1'b0, 1'b0},
		'{ROW_CFG,  8'd0,  1'b0, 1'b0},
		'{ROW_BYTE, 8'h55, 1'b1, 1'b0},
		'{ROW_BYTE, 8'h7E, 1'b1, 1'b0},
		'{ROW_BYTE, 8'h7D, 1'b0, 1'b0},
		'{ROW_BYTE, 8'h00, 1'b1, 1'b0},
		'{ROW_CFG,  8'd127, 1'b0, 1'b0}
	};

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_wr_en;
	logic [bsfr_pkg::CFG_W-1:0]  cfg_wr_data;
	logic                        in_valid;
	logic                        in_stall;
	logic [bsfr_pkg::BYTE_W-1:0] rx_byte;
	logic                        out_valid;
	logic                        out_stall;
	logic                        status;
	logic [bsfr_pkg::BYTE_W-1:0] data_byte;
	logic [bsfr_pkg::IDX_W-1:0]  byte_index;
	logic                        last;

	// predictor state
	logic [bsfr_pkg::CFG_W-1:0]  rx_max_len;
	bit                          rx_in_frame;
	bit                          rx_escape;
	int unsigned                 rx_body_len;
	logic [bsfr_pkg::BYTE_W-1:0] rx_store [STORE_DEPTH];

	frame_res_t  frame_out_q [$];
	bit          gaps_on;
	int unsigned mismatches;
	int unsigned quiet_cycles;
	int unsigned bytes_in;
	int unsigned results_seen;
	int unsigned frames_closed;
	int unsigned short_frames;
	int unsigned overflow_drops;

	byte_stuffed_frame_receiver_unit #(
		.MAX_BODY_BYTES(STORE_DEPTH)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.data_byte  (data_byte),
		.byte_index (byte_index),
		.last       (last)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic void deframe_byte(input logic [bsfr_pkg::BYTE_W-1:0] b, input bit keep);
		int unsigned lim;
		int unsigned i;
		logic [bsfr_pkg::BYTE_W-1:0] v;
		frame_res_t r;
		lim = (rx_max_len > STORE_DEPTH) ? STORE_DEPTH : rx_max_len;
		v = b;
		if (!rx_in_frame) begin
			if (b == bsfr_pkg::FLAG_BYTE) begin
				rx_in_frame = 1'b1;
				rx_escape = 1'b0;
				rx_body_len = 0;
			end
		end else if (b == bsfr_pkg::ESC_BYTE) begin
			rx_escape = 1'b1;
		end else if (b == bsfr_pkg::FLAG_BYTE) begin
			rx_escape = 1'b0;
			if (rx_body_len != 0) begin
				frames_closed++;
				if (rx_body_len < bsfr_pkg::MIN_FRAME) begin
					short_frames++;
					if (keep)
						frame_out_q.push_back(SHORT_RES);
				end else begin
					for (i = 0; i < rx_body_len; i++) begin
						r.status = bsfr_pkg::STATUS_OK;
						r.data = rx_store[i];
						r.idx = i[bsfr_pkg::IDX_W-1:0];
						r.last = (i + 1 == rx_body_len);
						if (keep)
							frame_out_q.push_back(r);
					end
				end
				rx_body_len = 0;
			end
		end else if (rx_body_len >= lim) begin
			overflow_drops++;
			rx_in_frame = 1'b0;
			rx_escape = 1'b0;
			rx_body_len = 0;
		end else begin
			if (rx_escape) begin
				v = b ^ bsfr_pkg::ESC_XOR;
				rx_escape = 1'b0;
			end
			rx_store[rx_body_len] = v;
			rx_body_len++;
		end
	endfunction

	task automatic send_byte(input logic [bsfr_pkg::BYTE_W-1:0] b, input bit keep);
		while (gaps_on && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		bytes_in++;
		deframe_byte(b, keep);
	endtask

	task automatic settle_idle();
		in_valid <= 1'b0;
		while (frame_out_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_max_len(input logic [bsfr_pkg::CFG_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		rx_max_len = v;
	endtask

	function automatic logic [bsfr_pkg::BYTE_W-1:0] line_byte();
		case ($urandom_range(7))
			0: line_byte = bsfr_pkg::FLAG_BYTE;
			1: line_byte = bsfr_pkg::ESC_BYTE;
			2: line_byte = bsfr_pkg::FLAG_BYTE ^ bsfr_pkg::ESC_XOR;
			default: line_byte = bsfr_pkg::BYTE_W'($urandom_range(255));
		endcase
	endfunction

	task automatic send_random_frame();
		int unsigned lim;
		int unsigned len;
		int unsigned pick;
		int unsigned k;
		logic [bsfr_pkg::BYTE_W-1:0] b;
		lim = (rx_max_len > STORE_DEPTH) ? STORE_DEPTH : rx_max_len;
		pick = $urandom_range(99);
		if (pick < 10) begin
			// line noise
			repeat ($urandom_range(1, 6)) send_byte(line_byte(), 1'b1);
			return;
		end
		if (!rx_in_frame || $urandom_range(3) == 0)
			send_byte(bsfr_pkg::FLAG_BYTE, 1'b1);
		if (pick < 16)
			len = lim;
		else if (pick < 22)
			len = lim + $urandom_range(1, 3);
		else if (pick < 32)
			len = $urandom_range(1, 2);
		else
			len = $urandom_range(bsfr_pkg::MIN_FRAME, (lim < 10) ? lim : 10);
		for (k = 0; k < len; k++) begin
			b = line_byte();
			if (b == bsfr_pkg::FLAG_BYTE || b == bsfr_pkg::ESC_BYTE ||
				$urandom_range(15) == 0) begin
				if ($urandom_range(29) == 0)
					send_byte(bsfr_pkg::ESC_BYTE, 1'b1);
				send_byte(bsfr_pkg::ESC_BYTE, 1'b1);
				send_byte(b ^ bsfr_pkg::ESC_XOR, 1'b1);
			end else begin
				send_byte(b, 1'b1);
			end
		end
		if ($urandom_range(19) == 0)
			send_byte(bsfr_pkg::ESC_BYTE, 1'b1);
		send_byte(bsfr_pkg::FLAG_BYTE, 1'b1);
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	always @(posedge clk) begin
		frame_res_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			results_seen++;
			if (frame_out_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0b data=%02h idx=%0d last=%0b",
					status, data_byte, byte_index, last));
			end else begin
				want = frame_out_q.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status %0b, want %0b", status, want.status));
				if (data_byte !== want.data)
					report_mismatch($sformatf("data_byte %02h, want %02h", data_byte, want.data));
				if (byte_index !== want.idx)
					report_mismatch($sformatf("byte_index %0d, want %0d", byte_index, want.idx));
				if (last !== want.last)
					report_mismatch($sformatf("last %0b, want %0b", last, want.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("no transfer for %0d cycles, %0d results outstanding",
				quiet_cycles, frame_out_q.size());
			$display("byte_stuffed_frame_receiver_unit regression: fail");
			$finish;
		end
	end

	always @(posedge clk)
		out_stall <= gaps_on && ($urandom_range(99) < 34);

	initial begin
		int unsigned ph;
		int unsigned phase_start;
		logic [bsfr_pkg::CFG_W-1:0] lim_sel;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		in_valid <= 1'b0;
		rx_byte <= '0;
		out_stall <= 1'b0;
		gaps_on = 1'b1;
		rx_max_len = bsfr_pkg::MAX_LEN_RESET;
		rx_in_frame = 1'b0;
		rx_escape = 1'b0;
		rx_body_len = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tbl[r]) begin
			if (dir_tbl[r].kind == ROW_CFG) begin
				settle_idle();
				set_max_len(dir_tbl[r].value[bsfr_pkg::CFG_W-1:0]);
			end else begin
				send_byte(dir_tbl[r].value, !dir_tbl[r].typed);
				if (dir_tbl[r].typed && dir_tbl[r].want_err)
					frame_out_q.push_back(SHORT_RES);
			end
		end

		for (ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: lim_sel = 7'd64;
				1: lim_sel = 7'd3;
				2: lim_sel = 7'd127;
				3: lim_sel = 7'd4;
				4: lim_sel = bsfr_pkg::CFG_W'($urandom_range(bsfr_pkg::MIN_FRAME, 127));
				default: lim_sel = bsfr_pkg::CFG_W'($urandom_range(bsfr_pkg::MIN_FRAME,
					STORE_DEPTH));
			endcase
			settle_idle();
			set_max_len(lim_sel);
			// hold back-to-back transfers on both sides for one phase
			gaps_on = (ph != 3);
			phase_start = bytes_in;
			while (bytes_in - phase_start < PHASE_BYTES)
				send_random_frame();
		end

		gaps_on = 1'b1;
		settle_idle();
		$display("covered %0d line bytes and %0d results over %0d limit settings",
			bytes_in, results_seen, N_PHASES + 3);
		$display("frames closed %0d, short %0d, dropped for length %0d, mismatches %0d",
			frames_closed, short_frames, overflow_drops, mismatches);
		if (mismatches == 0)
			$display("byte_stuffed_frame_receiver_unit regression: pass");
		else
			$display("byte_stuffed_frame_receiver_unit regression: fail");
		$finish;
	end

endmodule
